### design/pea_pkg.sv
// ----------------------------------------------------------------------------
// pea_pkg - shared constants for the protection entry allocator
// Field widths, stream packing offsets, operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package pea_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int ADDR_W = 64;   // region_base / region_size
    localparam int IDX_W  = 6;    // free_index / entry_index
    localparam int CFG_W  = 7;    // entries_in_use

    // slave tdata layout, lowest bit first
    localparam int S_BASE_LO   = 0;
    localparam int S_SIZE_LO   = S_BASE_LO + ADDR_W;
    localparam int S_LOCK_BIT  = S_SIZE_LO + ADDR_W;
    localparam int S_FIDX_LO   = S_LOCK_BIT + 1;
    localparam int S_FPAIR_BIT = S_FIDX_LO + IDX_W;
    localparam int S_TDATA_W   = S_FPAIR_BIT + 1;

    // master tdata layout, lowest bit first
    localparam int M_TDATA_W = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

### design/pea_entry_store.sv
// ----------------------------------------------------------------------------
// pea_entry_store - per-entry use count and lock bit
// One write port, one registered read port. Per-entry valid bits make every
// entry read as zero after reset until it is first written.
// ----------------------------------------------------------------------------
module pea_entry_store
    import pea_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
    input  logic [COUNT_BITS:0]            wr_data,   // {lock, count}
    input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
    output logic [COUNT_BITS:0]            rd_data    // {lock, count}, registered, valid in the cycle after rd_addr
);

    localparam int WORD_W = COUNT_BITS + 1;

    logic [WORD_W-1:0]      mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

### design/protection_entry_allocator.sv
// ----------------------------------------------------------------------------
// protection_entry_allocator - allocates and releases protection entries
//
// Input channel s_axis carries one request per item: tuser is the operation
// (allocate or free), tdata the region, lock request and free index. Output
// channel m_axis returns one result item per request: granted, entry index
// (top entry of a pair) and pair flag. cfg_wr_en/cfg_wr_data set how many
// entries the scan covers; write it only while no request is in flight.
//
// An allocate scans the entry store one entry per cycle through a single
// compare unit, over the entries_in_use entries, and then writes the picked
// entry or pair if one is found. A free reads and rewrites the freed entry
// or pair. One request is handled at a time; s_axis_tready is high only
// while the sequencer is idle, from the cycle after a result is handed to
// the output register.
//
// Reset clears all counts and lock bits (store valid bits) and sets the scan
// length to 64. A finished result sits in the output register; a new request
// can be accepted while it waits, and the next result waits for it to drain.
// ----------------------------------------------------------------------------
module protection_entry_allocator
    import pea_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,    // entries_in_use
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // region_base, region_size, want_locked,
                                                 // free_index, free_pair
    input  logic [0:0]           s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // granted, entry_index, is_pair
);

    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int CB     = COUNT_BITS;
    localparam logic [CB-1:0]    CNT_MAX = {CB{1'b1}};
    localparam logic [CFG_W-1:0] MAX_N   = CFG_W'(MAX_ENTRIES);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_FREE_RD   = 3'd1;
    localparam logic [2:0] ST_FREE_WR0  = 3'd2;
    localparam logic [2:0] ST_FREE_WR1  = 3'd3;
    localparam logic [2:0] ST_SCAN      = 3'd4;
    localparam logic [2:0] ST_ALLOC_WR0 = 3'd5;
    localparam logic [2:0] ST_ALLOC_WR1 = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    function automatic logic [CB-1:0] cnt_inc(input logic [CB-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CB-1:0] cnt_dec(input logic [CB-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    // control
    logic [2:0]           state_reg,    state_next;
    logic [CFG_W-1:0]     cfg_n_reg,    cfg_n_next;
    logic                 m_valid_reg,  m_valid_next;
    logic                 rd_pend_reg,  rd_pend_next;
    logic                 found_reg,    found_next;
    // payload
    logic [M_TDATA_W-1:0] m_data_reg,   m_data_next;
    logic                 single_reg,   single_next;
    logic                 locked_reg,   locked_next;
    logic [IDX_W-1:0]     fidx_reg,     fidx_next;
    logic                 fpair_reg,    fpair_next;
    logic [AW:0]          n_reg,        n_next;
    logic [AW:0]          rd_idx_reg,   rd_idx_next;
    logic [AW-1:0]        rd_pos_reg,   rd_pos_next;
    logic [CB:0]          prev_reg,     prev_next;
    logic [CB-1:0]        best_reg,     best_next;
    logic [AW-1:0]        pick_reg,     pick_next;
    logic [CB-1:0]        pick_a_reg,   pick_a_next;
    logic [CB-1:0]        pick_b_reg,   pick_b_next;
    logic                 res_gnt_reg,  res_gnt_next;
    logic [IDX_W-1:0]     res_idx_reg,  res_idx_next;
    logic                 res_pair_reg, res_pair_next;

    // store port
    logic          st_wr_en;
    logic [AW-1:0] st_wr_addr;
    logic [CB:0]   st_wr_data;
    logic [AW-1:0] st_rd_addr;
    logic [CB:0]   st_rd_data;

    // input fields
    logic [ADDR_W-1:0] in_base, in_size, in_mask;
    logic [IDX_W-1:0]  in_fidx;
    logic              in_single, in_fidx_ok, accept;
    logic [CFG_W-1:0]  n_eff;

    // shared candidate compare unit
    logic          ev_active, ev_last, ev_ok, ev_take;
    logic [AW-1:0] ev_idx;
    logic [CB-1:0] a_cnt, b_cnt, pair_cost, ev_cost;
    logic          a_lock, b_lock;
    logic [CB:0]   pair_sum;

    logic          issue;
    logic [AW-1:0] fidx_addr, fidx_lo_addr, pick_hi;

    pea_entry_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign in_base    = s_axis_tdata[S_BASE_LO +: ADDR_W];
    assign in_size    = s_axis_tdata[S_SIZE_LO +: ADDR_W];
    assign in_fidx    = s_axis_tdata[S_FIDX_LO +: IDX_W];
    // power-of-two size with base aligned to it, 64-bit wrapping
    assign in_mask    = in_size - 1'b1;
    assign in_single  = ((in_size & in_mask) == '0) && ((in_mask & in_base) == '0);
    assign in_fidx_ok = ({1'b0, in_fidx} < MAX_N);
    assign n_eff      = (cfg_n_reg > MAX_N) ? MAX_N : cfg_n_reg;

    assign fidx_addr    = fidx_reg[AW-1:0];
    assign fidx_lo_addr = fidx_addr - 1'b1;
    assign pick_hi      = pick_reg + 1'b1;
    assign issue        = (rd_idx_reg < n_reg);

    // candidate at ev_idx: a = that entry, b = entry above it
    assign a_cnt     = prev_reg[CB-1:0];
    assign a_lock    = prev_reg[CB];
    assign b_cnt     = st_rd_data[CB-1:0];
    assign b_lock    = st_rd_data[CB];
    assign pair_sum  = {1'b0, a_cnt} + {1'b0, b_cnt};
    assign pair_cost = pair_sum[CB] ? CNT_MAX : pair_sum[CB-1:0];
    assign ev_cost   = single_reg ? a_cnt : pair_cost;

    always_comb
    begin
        if (locked_reg)
        begin
            ev_ok   = (a_cnt == '0) && (single_reg || (!ev_last && (b_cnt == '0)));
            ev_take = ev_active && ev_ok && !found_reg;
        end
        else
        begin
            ev_ok   = !a_lock && (single_reg || (!ev_last && !b_lock));
            ev_take = ev_active && ev_ok && (ev_cost < best_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cfg_n_next    = cfg_wr_en ? cfg_wr_data : cfg_n_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        rd_pend_next  = rd_pend_reg;
        found_next    = found_reg;
        single_next   = single_reg;
        locked_next   = locked_reg;
        fidx_next     = fidx_reg;
        fpair_next    = fpair_reg;
        n_next        = n_reg;
        rd_idx_next   = rd_idx_reg;
        rd_pos_next   = rd_pos_reg;
        prev_next     = prev_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        pick_a_next   = pick_a_reg;
        pick_b_next   = pick_b_reg;
        res_gnt_next  = res_gnt_reg;
        res_idx_next  = res_idx_reg;
        res_pair_next = res_pair_reg;
        st_wr_en      = 1'b0;
        st_wr_addr    = pick_reg;
        st_wr_data    = '0;
        st_rd_addr    = '0;
        ev_active     = 1'b0;
        ev_last       = 1'b0;
        ev_idx        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    single_next = in_single;
                    locked_next = s_axis_tdata[S_LOCK_BIT];
                    fidx_next   = in_fidx;
                    fpair_next  = s_axis_tdata[S_FPAIR_BIT] && (in_fidx != '0);
                    n_next      = (AW+1)'(n_eff);
                    rd_idx_next = '0;
                    rd_pend_next = 1'b0;
                    found_next  = 1'b0;
                    best_next   = CNT_MAX;
                    if (s_axis_tuser[0] == OP_FREE)
                    begin
                        if (in_fidx_ok)
                        begin
                            state_next = ST_FREE_RD;
                        end
                        else
                        begin
                            res_gnt_next  = 1'b0;
                            res_idx_next  = in_fidx;
                            res_pair_next = 1'b0;
                            state_next    = ST_DONE;
                        end
                    end
                    else if (n_eff == '0)
                    begin
                        res_gnt_next  = 1'b0;
                        res_idx_next  = '0;
                        res_pair_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_FREE_RD:
            begin
                st_rd_addr = fidx_addr;
                state_next = ST_FREE_WR0;
            end

            ST_FREE_WR0:
            begin
                st_wr_en      = 1'b1;
                st_wr_addr    = fidx_addr;
                st_wr_data    = {1'b0, cnt_dec(st_rd_data[CB-1:0])};
                st_rd_addr    = fidx_lo_addr;
                res_gnt_next  = 1'b1;
                res_idx_next  = fidx_reg;
                res_pair_next = fpair_reg;
                state_next    = fpair_reg ? ST_FREE_WR1 : ST_DONE;
            end

            ST_FREE_WR1:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = fidx_lo_addr;
                st_wr_data = {1'b0, cnt_dec(st_rd_data[CB-1:0])};
                state_next = ST_DONE;
            end

            ST_SCAN:
            begin
                st_rd_addr   = rd_idx_reg[AW-1:0];
                rd_pend_next = issue;
                rd_pos_next  = rd_idx_reg[AW-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    prev_next = st_rd_data;
                    if (rd_pos_reg != '0)
                    begin
                        ev_active = 1'b1;
                        ev_idx    = rd_pos_reg - 1'b1;
                    end
                end
                else if (!issue)
                begin
                    // last scanned entry, never the bottom of a pair
                    ev_active = 1'b1;
                    ev_last   = 1'b1;
                    ev_idx    = AW'(n_reg - 1'b1);
                    if (found_reg || ev_take)
                    begin
                        state_next = ST_ALLOC_WR0;
                    end
                    else
                    begin
                        res_gnt_next  = 1'b0;
                        res_idx_next  = '0;
                        res_pair_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                end
                if (ev_take)
                begin
                    found_next  = 1'b1;
                    best_next   = ev_cost;
                    pick_next   = ev_idx;
                    pick_a_next = a_cnt;
                    pick_b_next = b_cnt;
                end
            end

            ST_ALLOC_WR0:
            begin
                st_wr_en      = 1'b1;
                st_wr_addr    = pick_reg;
                st_wr_data    = {locked_reg, cnt_inc(pick_a_reg)};
                res_gnt_next  = 1'b1;
                res_idx_next  = single_reg ? IDX_W'(pick_reg) : IDX_W'(pick_hi);
                res_pair_next = !single_reg;
                state_next    = single_reg ? ST_DONE : ST_ALLOC_WR1;
            end

            ST_ALLOC_WR1:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = pick_hi;
                st_wr_data = {locked_reg, cnt_inc(pick_b_reg)};
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_pair_reg, res_idx_reg, res_gnt_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cfg_n_reg   <= MAX_N;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cfg_n_reg   <= cfg_n_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg   <= m_data_next;
        single_reg   <= single_next;
        locked_reg   <= locked_next;
        fidx_reg     <= fidx_next;
        fpair_reg    <= fpair_next;
        n_reg        <= n_next;
        rd_idx_reg   <= rd_idx_next;
        rd_pos_reg   <= rd_pos_next;
        prev_reg     <= prev_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        pick_a_reg   <= pick_a_next;
        pick_b_reg   <= pick_b_next;
        res_gnt_reg  <= res_gnt_next;
        res_idx_reg  <= res_idx_next;
        res_pair_reg <= res_pair_next;
    end

endmodule

### bench/tb_protection_entry_allocator.sv
// ----------------------------------------------------------------------------
// tb_protection_entry_allocator - self-checking bench for the entry allocator
// Drives allocate and free requests over the request stream and mirrors entry
// counts and lock bits in a scoreboard that predicts every result item. Walks
// several scan lengths, including zero and values past the entry count, with
// random stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_protection_entry_allocator;
    import pea_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int COUNT_MAX      = (1 << COUNT_BITS_DEF) - 1;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        bit             pair;
        bit [IDX_W-1:0] idx;
        bit             granted;
    } alloc_result_t;

    class allocation_scoreboard;
        bit [COUNT_BITS_DEF-1:0] use_cnt [MAX_ENTRIES_DEF];
        bit                      lock_bit [MAX_ENTRIES_DEF];
        bit [CFG_W-1:0]          scan_len;
        alloc_result_t           expected_q [$];
        int                      mismatches;
        int                      checked;
        int                      n_alloc;
        int                      n_grant;
        int                      n_refused;
        int                      n_free;

        function new();
            foreach (use_cnt[i])
            begin
                use_cnt[i]  = '0;
                lock_bit[i] = 1'b0;
            end
            scan_len = 7'd64;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit [COUNT_BITS_DEF-1:0] count_up(bit [COUNT_BITS_DEF-1:0] c);
            return (c == COUNT_MAX) ? c : c + 1'b1;
        endfunction

        function bit [COUNT_BITS_DEF-1:0] count_down(bit [COUNT_BITS_DEF-1:0] c);
            return (c == 0) ? c : c - 1'b1;
        endfunction

        // works out the result of one accepted request and updates the entry state
        function void note_request(bit op, bit [ADDR_W-1:0] base, bit [ADDR_W-1:0] size,
                                   bit locked, bit [IDX_W-1:0] fidx, bit fpair);
            alloc_result_t res;
            bit [ADDR_W-1:0] mask;
            bit single;
            bit found;
            bit last;
            bit usable;
            int n;
            int pick;
            int best;
            int cost;
            res = '0;
            if (op == OP_FREE)
            begin
                n_free++;
                res.idx = fidx;
                if (fidx < MAX_ENTRIES_DEF)
                begin
                    res.granted    = 1'b1;
                    use_cnt[fidx]  = count_down(use_cnt[fidx]);
                    lock_bit[fidx] = 1'b0;
                    if (fpair && fidx != 0)
                    begin
                        use_cnt[fidx-1]  = count_down(use_cnt[fidx-1]);
                        lock_bit[fidx-1] = 1'b0;
                        res.pair         = 1'b1;
                    end
                end
                expected_q.push_back(res);
                return;
            end
            n_alloc++;
            n      = (scan_len > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : scan_len;
            mask   = size - 1'b1;
            single = ((size & mask) == 0) && ((mask & base) == 0);
            found  = 1'b0;
            pick   = 0;
            best   = COUNT_MAX;
            for (int i = 0; i < n; i++)
            begin
                last = (i + 1 == n);
                if (locked)
                begin
                    // first free entry or pair, lock bits do not matter here
                    if (!found && use_cnt[i] == 0 &&
                        (single || (!last && use_cnt[i+1] == 0)))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                else if (!lock_bit[i])
                begin
                    usable = single || !(last || lock_bit[i+1]);
                    cost   = use_cnt[i];
                    if (!single && usable)
                    begin
                        cost += use_cnt[i+1];
                        if (cost > COUNT_MAX)
                            cost = COUNT_MAX;
                    end
                    // strict compare: ties keep the lower index, saturated cost never wins
                    if (usable && cost < best)
                    begin
                        best  = cost;
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found)
            begin
                n_grant++;
                use_cnt[pick] = count_up(use_cnt[pick]);
                if (locked)
                    lock_bit[pick] = 1'b1;
                if (!single)
                begin
                    pick++;
                    use_cnt[pick] = count_up(use_cnt[pick]);
                    if (locked)
                        lock_bit[pick] = 1'b1;
                end
                res.granted = 1'b1;
                res.idx     = pick[IDX_W-1:0];
                res.pair    = !single;
            end
            else
                n_refused++;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] got);
            alloc_result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result item %h arrived with nothing outstanding", got);
                return;
            end
            want = expected_q.pop_front();
            if (got[0] !== want.granted || got[IDX_W:1] !== want.idx ||
                got[IDX_W+1] !== want.pair)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: want g=%0d i=%0d p=%0d, got g=%0b i=%0d p=%0b",
                             checked, want.granted, want.idx, want.pair,
                             got[0], got[IDX_W:1], got[IDX_W+1]);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    allocation_scoreboard sb;
    bit                   no_idle;
    int                   cycles;

    protection_entry_allocator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, sb.pending());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stalls plus one long hold-off that backs up the block
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.checked >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // called and left at a falling edge; tvalid stays up until a later call or a scan change replaces or lowers it
    task automatic send_request(bit op, bit [ADDR_W-1:0] base, bit [ADDR_W-1:0] size,
                                bit locked, bit [IDX_W-1:0] fidx, bit fpair);
        logic [S_TDATA_W-1:0] data;
        data                          = '0;
        data[S_BASE_LO +: ADDR_W]     = base;
        data[S_SIZE_LO +: ADDR_W]     = size;
        data[S_LOCK_BIT]              = locked;
        data[S_FIDX_LO +: IDX_W]      = fidx;
        data[S_FPAIR_BIT]             = fpair;
        while (!no_idle && $urandom_range(0, 99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        sb.note_request(op, base, size, locked, fidx, fpair);
        @(negedge clk);
    endtask

    task automatic set_scan_length(int unsigned value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.scan_len = value[CFG_W-1:0];
    endtask

    task automatic send_random_request(int unsigned scan);
        bit [ADDR_W-1:0] base;
        bit [ADDR_W-1:0] size;
        bit [IDX_W-1:0]  fidx;
        bit              op;
        bit              locked;
        bit              fpair;
        int              k;
        int              lim;
        base   = {$urandom, $urandom};
        size   = {$urandom, $urandom};
        locked = ($urandom_range(0, 99) < 40);
        fpair  = ($urandom_range(0, 2) == 0);
        fidx   = IDX_W'($urandom_range(0, MAX_ENTRIES_DEF - 1));
        op     = ($urandom_range(0, 99) < 58) ? OP_ALLOC : OP_FREE;
        if (op == OP_ALLOC)
        begin
            k = $urandom_range(0, ADDR_W - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // naturally aligned, mostly small sizes
                    if ($urandom_range(0, 3) != 0)
                        k = $urandom_range(0, 12);
                    size = 64'd1 << k;
                    base = base & ~(size - 1'b1);
                end
                5, 6:
                begin
                    // power-of-two size on a misaligned base (aligned when the size is one)
                    size = 64'd1 << k;
                    base = (base & ~(size - 1'b1)) | (size >> 1) | (k == 0 ? 64'd0 : 64'd1);
                end
                7:
                begin
                    size = '0;
                    if ($urandom_range(0, 1) == 0)
                        base = '0;
                end
                default: ;
            endcase
        end
        else
        begin
            // keep most frees inside the scanned range so entries get recycled
            lim = (scan > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : ((scan == 0) ? 1 : scan);
            if ($urandom_range(0, 99) < 85)
                fidx = IDX_W'($urandom_range(0, lim - 1));
        end
        send_request(op, base, size, locked, fidx, fpair);
    endtask

    initial
    begin
        int unsigned scan_plan [13];
        int          item_plan [13];
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ALLOC;
        no_idle       = 1'b0;
        sb            = new();
        scan_plan = '{64, 1, 8, 0, 100, 2, 16, 3, 127, 5, 64, 33, 12};
        item_plan = '{150, 80, 150, 20, 60, 100, 150, 100, 30, 140, 150, 150, 250};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: alignment corners, lock modes, free corner cases at full scan
        send_request(OP_ALLOC, 64'd0, 64'd0, 1'b1, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'd1, 64'd0, 1'b1, 6'd0, 1'b0);
        send_request(OP_ALLOC, '1, 64'd1, 1'b0, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'h1000, 64'h3000, 1'b0, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1,
                     6'd0, 1'b0);
        send_request(OP_ALLOC, '1, '1, 1'b0, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'd0, 64'h8000_0000_0000_0000, 1'b0, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'h40, 64'h20, 1'b1, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'h30, 64'h20, 1'b1, 6'd0, 1'b0);
        send_request(OP_FREE, 64'd0, 64'd0, 1'b0, 6'd0, 1'b1);
        send_request(OP_FREE, 64'd0, 64'd0, 1'b0, 6'd63, 1'b1);
        send_request(OP_FREE, 64'd0, 64'd0, 1'b0, 6'd40, 1'b0);
        send_request(OP_FREE, 64'd0, 64'd0, 1'b0, 6'd2, 1'b1);
        send_request(OP_ALLOC, 64'd0, 64'd8, 1'b0, '1, 1'b1);
        send_request(OP_FREE, '1, '1, 1'b1, 6'd63, 1'b0);

        // tiny scans: last entry cannot start a pair, locked requests run out
        set_scan_length(2);
        send_request(OP_ALLOC, 64'd3, 64'd5, 1'b0, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'd3, 64'd5, 1'b1, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'd0, 64'd4, 1'b1, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'd0, 64'd4, 1'b1, 6'd0, 1'b0);
        set_scan_length(1);
        send_request(OP_ALLOC, 64'd7, 64'd3, 1'b0, 6'd0, 1'b0);
        send_request(OP_ALLOC, 64'd0, 64'd1, 1'b0, 6'd0, 1'b0);

        for (int p = 0; p < 13; p++)
        begin
            set_scan_length(scan_plan[p]);
            no_idle = (p == 6);
            for (int i = 0; i < item_plan[p]; i++)
                send_random_request(scan_plan[p]);
        end
        no_idle = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("ran %0d requests: %0d allocates (%0d granted, %0d refused), %0d frees",
                 sb.n_alloc + sb.n_free, sb.n_alloc, sb.n_grant, sb.n_refused, sb.n_free);
        $display("scan lengths 0 to 127 visited, %0d result items checked, %0d bad",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
